// ===== src/prca_pkg.sv =====
// Package for the per-residue contact average block.
// Field widths, the store entry layout, sequencer states and divider status.
// No dependencies.
package prca_pkg;

	localparam int RES_W          = 11;
	localparam int PROB_W         = 17;
	localparam int SUM_W          = 33;
	localparam int CNT_W          = 17;
	localparam int PROB_FRAC_BITS = 16;
	localparam int ENTRY_W        = SUM_W + CNT_W;
	localparam int DIV_CNT_W      = $clog2(CNT_W);

	localparam logic [PROB_W-1:0] PROB_ONE          = PROB_W'(1 << PROB_FRAC_BITS);
	localparam logic [RES_W-1:0]  RESIDUE_COUNT_RST = RES_W'(1024);

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_LOAD_A,
		ST_LOAD_B,
		ST_UPD,
		ST_WR_B,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== src/prca_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module prca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== src/prca_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Sum by count; quotient assumed to fit CNT_W bits. Uses prca_pkg.
module prca_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [prca_pkg::SUM_W-1:0] dividend,
	input  logic [prca_pkg::CNT_W-1:0] divisor,
	output prca_pkg::div_stat_t        stat,
	output logic [prca_pkg::CNT_W-1:0] quotient
);
	import prca_pkg::*;

	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     low_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W+1:0]     diff;
	logic                 ge;

	assign diff = {1'b0, rem_q, low_q[CNT_W-1]} - {2'b00, dvs_q};
	assign ge   = !diff[CNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(CNT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[SUM_W-1:CNT_W]};
			low_q <= dividend[CNT_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : {rem_q[CNT_W-2:0], low_q[CNT_W-1]};
			low_q <= {low_q[CNT_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = low_q;

endmodule

// ===== src/per_residue_contact_average.sv =====
// Top level: per-residue running mean of contact probabilities.
// Uses prca_pkg, prca_ram (sum/count store) and prca_div (serial divider).
//
// channel   direction  handshake            payload
// in        request    in_valid/in_ready    func, focus_residue, partner_residue, probability
// out       result     out_valid/out_ready  avg_probability, has_contacts, error
// cfg       write      cfg_wr_en            cfg_wr_data (residue_count)
//
// Add of two residues: CHECK, LOAD_A, LOAD_B, UPD, WR_B, DONE; same residue skips LOAD_B, WR_B;
// overflow or error goes to DONE early. Read: 17-step divider; read of an empty entry skips it.
// After reset a clearing pass writes MAX_RESIDUES store entries, one a cycle;
// in_ready stays low meanwhile. One request is in work at a time, through the
// single store port; the next is taken while the result waits in the output register.
module per_residue_contact_average #(
	parameter int MAX_RESIDUES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [prca_pkg::RES_W-1:0]  focus_residue,
	input  logic [prca_pkg::RES_W-1:0]  partner_residue,
	input  logic [prca_pkg::PROB_W-1:0] probability,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [prca_pkg::PROB_W-1:0] avg_probability,
	output logic                        has_contacts,
	output logic                        error,
	input  logic                        cfg_wr_en,
	input  logic [prca_pkg::RES_W-1:0]  cfg_wr_data
);
	import prca_pkg::*;

	localparam int AW    = $clog2(MAX_RESIDUES);
	localparam int LIM_W = (AW + 1 > RES_W) ? AW + 1 : RES_W;

	state_t              state_q, state_d;
	logic [AW-1:0]       clr_addr_q;
	logic [RES_W-1:0]    residue_count_q;
	logic                func_q;
	logic [AW-1:0]       a_addr_q;
	logic [AW-1:0]       b_addr_q;
	logic                same_q;
	logic                ok_q;
	logic [PROB_W-1:0]   prob_q;
	entry_t              ent_a_q;
	entry_t              ent_b_q;
	logic                res_err_q;
	logic                res_has_q;
	logic [PROB_W-1:0]   res_avg_q;
	logic                out_valid_q;
	logic [PROB_W-1:0]   out_avg_q;
	logic                out_has_q;
	logic                out_err_q;

	logic                accept;
	logic                out_load;
	logic [LIM_W-1:0]    lim;
	logic [LIM_W-1:0]    focus_w;
	logic [LIM_W-1:0]    partner_w;
	logic [LIM_W-1:0]    focus_m1;
	logic [LIM_W-1:0]    partner_m1;
	logic                focus_ok;
	logic                partner_ok;

	logic                ram_en;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	entry_t              ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata_raw;
	entry_t              ram_rdata;

	logic                div_start;
	div_stat_t           div_stat;
	logic [CNT_W-1:0]    div_quot;

	logic [CNT_W:0]      inc_a;
	logic [SUM_W:0]      add_a;
	logic [CNT_W:0]      nca;
	logic [SUM_W:0]      nsa;
	logic [CNT_W:0]      ncb;
	logic [SUM_W:0]      nsb;
	logic                ovf;
	entry_t              new_a;
	entry_t              new_b;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// residue range check against min(residue_count, MAX_RESIDUES)
	assign lim = (LIM_W'(residue_count_q) > LIM_W'(MAX_RESIDUES)) ?
		LIM_W'(MAX_RESIDUES) : LIM_W'(residue_count_q);
	assign focus_w    = LIM_W'(focus_residue);
	assign partner_w  = LIM_W'(partner_residue);
	assign focus_m1   = focus_w - LIM_W'(1);
	assign partner_m1 = partner_w - LIM_W'(1);
	assign focus_ok   = (focus_w != '0) && (focus_w <= lim);
	assign partner_ok = (partner_w != '0) && (partner_w <= lim);

	// entry update
	assign inc_a = same_q ? (CNT_W+1)'(2) : (CNT_W+1)'(1);
	assign add_a = same_q ? (SUM_W+1)'({prob_q, 1'b0}) : (SUM_W+1)'(prob_q);
	assign nca   = {1'b0, ent_a_q.cnt} + inc_a;
	assign nsa   = {1'b0, ent_a_q.sum} + add_a;
	assign ncb   = {1'b0, ent_b_q.cnt} + (CNT_W+1)'(1);
	assign nsb   = {1'b0, ent_b_q.sum} + (SUM_W+1)'(prob_q);
	assign ovf   = nca[CNT_W] || nsa[SUM_W] || (!same_q && (ncb[CNT_W] || nsb[SUM_W]));
	assign new_a.cnt = nca[CNT_W-1:0];
	assign new_a.sum = nsa[SUM_W-1:0];
	assign new_b.cnt = ncb[CNT_W-1:0];
	assign new_b.sum = nsb[SUM_W-1:0];

	assign ram_rdata = entry_t'(ram_rdata_raw);

	prca_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RESIDUES)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata_raw)
	);

	prca_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(ram_rdata.sum),
		.divisor (ram_rdata.cnt),
		.stat    (div_stat),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = a_addr_q;
		ram_wdata = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_addr_q;
				if (clr_addr_q == AW'(MAX_RESIDUES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!ok_q) begin
					state_d = ST_DONE;
				end else begin
					ram_en  = 1'b1;
					state_d = ST_LOAD_A;
				end
			end
			ST_LOAD_A: begin
				if (func_q == FUNC_READ) begin
					ram_en = 1'b1;
					ram_we = 1'b1;
					if (ram_rdata.cnt != '0) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end else if (same_q) begin
					state_d = ST_UPD;
				end else begin
					ram_en   = 1'b1;
					ram_addr = b_addr_q;
					state_d  = ST_LOAD_B;
				end
			end
			ST_LOAD_B: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (ovf) begin
					state_d = ST_DONE;
				end else begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_wdata = new_a;
					state_d   = same_q ? ST_DONE : ST_WR_B;
				end
			end
			ST_WR_B: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = b_addr_q;
				ram_wdata = ent_b_q;
				state_d   = ST_DONE;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q      <= '0;
			residue_count_q <= RESIDUE_COUNT_RST;
			out_valid_q     <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cfg_wr_en) begin
				residue_count_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			a_addr_q  <= focus_m1[AW-1:0];
			b_addr_q  <= partner_m1[AW-1:0];
			same_q    <= (focus_residue == partner_residue);
			ok_q      <= focus_ok && ((func == FUNC_READ) || partner_ok);
			res_err_q <= !(focus_ok && ((func == FUNC_READ) || partner_ok));
			prob_q    <= (probability > PROB_ONE) ? PROB_ONE : probability;
			res_has_q <= 1'b0;
			res_avg_q <= '0;
		end
		if (state_q == ST_LOAD_A) begin
			ent_a_q <= ram_rdata;
		end
		if (state_q == ST_LOAD_B) begin
			ent_b_q <= ram_rdata;
		end
		if (state_q == ST_UPD) begin
			ent_b_q <= new_b;
			if (ovf) begin
				res_err_q <= 1'b1;
			end
		end
		if ((state_q == ST_DIV) && div_stat.done) begin
			res_has_q <= 1'b1;
			res_avg_q <= PROB_W'(div_quot);
		end
		if (out_load) begin
			out_avg_q <= res_avg_q;
			out_has_q <= res_has_q;
			out_err_q <= res_err_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign avg_probability = out_avg_q;
	assign has_contacts    = out_has_q;
	assign error           = out_err_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide state");

	a_avg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> PROB_W'(div_quot) <= PROB_ONE)
		else $error("average above one");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !ram_we)
		else $error("store written while no request in work");

	a_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_has_q && out_err_q))
		else $error("result with both contacts and error");

endmodule
